>>> sv/rau_pkg.sv
// Shared types, codes and defaults for the rational arithmetic unit.
package rau_pkg;

   localparam int WORD_BITS_DEF = 32;

   localparam logic [2:0] FN_REDUCE  = 3'd0;
   localparam logic [2:0] FN_ADD     = 3'd1;
   localparam logic [2:0] FN_SUB     = 3'd2;
   localparam logic [2:0] FN_MUL     = 3'd3;
   localparam logic [2:0] FN_DIV     = 3'd4;
   localparam logic [2:0] FN_NEGATE  = 3'd5;
   localparam logic [2:0] FN_COMPARE = 3'd6;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_ZERO = 2'd1;
   localparam logic [1:0] ERR_OVF  = 2'd2;

   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   localparam logic [1:0] MSEL_P = 2'd0;
   localparam logic [1:0] MSEL_Q = 2'd1;
   localparam logic [1:0] MSEL_R = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         order;
      logic [1:0]         error;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_PREP, S_GCD,
      S_DSTART_N, S_DIV_N, S_DSTART_D, S_DIV_D, S_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_MUL, OP_PREP, OP_GCD, OP_DIV_START, OP_DIV_STEP, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] mul_sel;
      logic       den_sel;
   } cmd_type;

   typedef struct packed {
      logic fast;
      logic gcd_done;
      logic out_free;
   } status_type;

endpackage

>>> sv/rau_if.sv
// Valid/ready channel interfaces for request and response items.
interface rau_req_if;
   logic             valid;
   logic             ready;
   rau_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rau_rsp_if;
   logic             valid;
   logic             ready;
   rau_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/rau_datapath.sv
// Datapath: operand registers, shared multiplier, binary gcd, restoring divider.
module rau_datapath #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  rau_pkg::cmd_type    cmd,
   output rau_pkg::status_type status,
   input  rau_pkg::req_type    req_data,
   output rau_pkg::rsp_type    rsp_data,
   output logic                rsp_valid,
   input  logic                rsp_ready
);
   import rau_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W + 2;
   localparam int KW = $clog2(W);

   function automatic logic fits(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = v >>> (W - 1);
      return (t == '0) || (t == '1);
   endfunction

   logic [2:0]           func_ff, func_in;
   logic signed [W:0]    an_ff, ad_ff, bn_ff, bd_ff, an_in, ad_in, bn_in, bd_in;
   logic signed [PW-1:0] p_ff, q_ff, r_ff, p_in, q_in, r_in;
   logic [1:0]           err_ff, err_in, ord_ff, ord_in;
   logic                 neg_ff, neg_in, fast_ff, fast_in;
   logic [W-1:0]         x_ff, x_in, y_ff, y_in, mn_ff, mn_in, md_ff, md_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [W:0]           rem_ff, rem_in;
   logic [W-1:0]         quo_ff, quo_in, dvs_ff, dvs_in, qn_ff, qn_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [W:0]    op1, op2, la, lb, lc, ld;
   logic signed [PW-1:0] prod, n_v, d_v, s_v, n_mag, d_mag;
   logic                 zero_err, ovf;
   logic [W:0]           rem2;
   logic [W-1:0]         wnum;
   logic                 fin_ovf;

   always_comb begin
      la = {req_data.a_num[W-1], req_data.a_num[W-1:0]};
      ld = {req_data.a_den[W-1], req_data.a_den[W-1:0]};
      lb = {req_data.b_num[W-1], req_data.b_num[W-1:0]};
      lc = {req_data.b_den[W-1], req_data.b_den[W-1:0]};
      if (req_data.func == FN_COMPARE && ld < 0) begin
         la = -la;
         ld = -ld;
      end
      if (req_data.func == FN_COMPARE && lc < 0) begin
         lb = -lb;
         lc = -lc;
      end
   end

   always_comb begin
      case (cmd.mul_sel)
         MSEL_P: begin
            op1 = an_ff;
            op2 = (func_ff == FN_MUL) ? bn_ff : bd_ff;
         end
         MSEL_Q: begin
            op1 = ad_ff;
            op2 = (func_ff == FN_MUL) ? bd_ff : bn_ff;
         end
         default: begin
            op1 = ad_ff;
            op2 = bd_ff;
         end
      endcase
      prod = op1 * op2;
   end

   // operand checks and fraction setup
   always_comb begin
      zero_err = (ad_ff == 0);
      ovf      = 1'b0;
      n_v      = '0;
      d_v      = PW'(1);
      s_v      = (func_ff == FN_ADD) ? p_ff + q_ff : p_ff - q_ff;
      ord_in   = ORD_LESS;
      case (func_ff)
         FN_REDUCE, FN_NEGATE: begin
            n_v = (func_ff == FN_NEGATE) ? -PW'(an_ff) : PW'(an_ff);
            d_v = PW'(ad_ff);
         end
         FN_ADD, FN_SUB: begin
            zero_err = zero_err || (bd_ff == 0);
            ovf = !fits(p_ff) || !fits(q_ff) || !fits(s_v) || !fits(r_ff);
            n_v = s_v;
            d_v = r_ff;
         end
         FN_MUL, FN_DIV: begin
            zero_err = zero_err || (bd_ff == 0) || (func_ff == FN_DIV && bn_ff == 0);
            ovf = !fits(p_ff) || !fits(q_ff);
            n_v = p_ff;
            d_v = q_ff;
         end
         FN_COMPARE: begin
            zero_err = zero_err || (bd_ff == 0);
            if (p_ff < q_ff)       ord_in = ORD_LESS;
            else if (p_ff == q_ff) ord_in = ORD_EQUAL;
            else                   ord_in = ORD_GREATER;
         end
         default: begin
            zero_err = 1'b0;
         end
      endcase
      if (zero_err) begin
         ord_in = ORD_LESS;
         err_in = ERR_ZERO;
      end else if (ovf) begin
         err_in = ERR_OVF;
      end else begin
         err_in = ERR_NONE;
      end
      n_mag = (n_v < 0) ? -n_v : n_v;
      d_mag = (d_v < 0) ? -d_v : d_v;
   end

   always_comb begin
      rem2    = {rem_ff[W-1:0], quo_ff[W-1]};
      fin_ovf = quo_ff[W-1] || (neg_ff ? (qn_ff[W-1] && (|qn_ff[W-2:0])) : qn_ff[W-1]);
      wnum    = neg_ff ? -qn_ff : qn_ff;
   end

   always_comb begin
      func_in = func_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      p_in = p_ff; q_in = q_ff; r_in = r_ff;
      neg_in = neg_ff; fast_in = fast_ff;
      x_in = x_ff; y_in = y_ff; k_in = k_ff; mn_in = mn_ff; md_in = md_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; qn_in = qn_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (cmd.op)
         OP_LOAD: begin
            func_in = req_data.func;
            an_in = la; ad_in = ld; bn_in = lb; bd_in = lc;
         end
         OP_MUL: begin
            case (cmd.mul_sel)
               MSEL_P:  p_in = prod;
               MSEL_Q:  q_in = prod;
               default: r_in = prod;
            endcase
         end
         OP_PREP: begin
            fast_in = zero_err || ovf || (n_v == 0) || func_ff == FN_COMPARE
                      || func_ff == 3'd7;
            neg_in = (n_v < 0) ^ (d_v < 0);
            x_in   = n_mag[W-1:0];
            y_in   = d_mag[W-1:0];
            mn_in  = n_mag[W-1:0];
            md_in  = d_mag[W-1:0];
            k_in   = '0;
         end
         OP_GCD: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff > y_ff) begin
               x_in = x_ff - y_ff;
            end else if (y_ff > x_ff) begin
               y_in = y_ff - x_ff;
            end
         end
         OP_DIV_START: begin
            dvs_in = x_ff << k_ff;
            rem_in = '0;
            quo_in = cmd.den_sel ? md_ff : mn_ff;
            if (cmd.den_sel) qn_in = quo_ff;
         end
         OP_DIV_STEP: begin
            if (rem2 >= {1'b0, dvs_ff}) begin
               rem_in = rem2 - {1'b0, dvs_ff};
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem2;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
         end
         OP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.res_num = '0;
            rsp_in.res_den = 31'd1;
            rsp_in.order   = ORD_LESS;
            rsp_in.error   = ERR_NONE;
            if (fast_ff) begin
               rsp_in.order = ord_ff;
               rsp_in.error = err_ff;
            end else if (fin_ovf) begin
               rsp_in.error = ERR_OVF;
            end else begin
               rsp_in.res_num = 32'($signed(wnum));
               rsp_in.res_den = 31'(quo_ff[W-2:0]);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      p_ff <= p_in; q_ff <= q_in; r_ff <= r_in;
      if (cmd.op == OP_PREP) begin
         err_ff <= err_in;
         ord_ff <= ord_in;
      end
      neg_ff <= neg_in; fast_ff <= fast_in;
      x_ff <= x_in; y_ff <= y_in; k_ff <= k_in; mn_ff <= mn_in; md_ff <= md_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; qn_ff <= qn_in;
      rsp_ff <= rsp_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   assign status.fast     = fast_ff;
   assign status.gcd_done = x_ff[0] && y_ff[0] && (x_ff == y_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/rau_controller.sv
// Controller: sequences multiply, check, gcd and two divisions per item; fast items skip gcd and division.
module rau_controller #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rau_pkg::status_type status,
   output rau_pkg::cmd_type    cmd
);
   import rau_pkg::*;

   localparam int CW = $clog2(WORD_BITS);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd.op      = OP_NONE;
      cmd.mul_sel = MSEL_P;
      cmd.den_sel = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.op = OP_MUL; cmd.mul_sel = MSEL_P; state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.op = OP_MUL; cmd.mul_sel = MSEL_Q; state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op = OP_MUL; cmd.mul_sel = MSEL_R; state_in = S_PREP;
         end
         S_PREP: begin
            cmd.op = OP_PREP; state_in = S_GCD;
         end
         S_GCD: begin
            if (status.fast)          state_in = S_FIN;
            else if (status.gcd_done) state_in = S_DSTART_N;
            else                      cmd.op = OP_GCD;
         end
         S_DSTART_N: begin
            cmd.op = OP_DIV_START; cnt_in = '0; state_in = S_DIV_N;
         end
         S_DIV_N: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WORD_BITS - 1)) state_in = S_DSTART_D;
         end
         S_DSTART_D: begin
            cmd.op = OP_DIV_START; cmd.den_sel = 1'b1; cnt_in = '0; state_in = S_DIV_D;
         end
         S_DIV_D: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WORD_BITS - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> sv/rational_arithmetic_unit.sv
// One item at a time: load, three multiplies and checks, a binary gcd, then two
// restoring divisions of WORD_BITS quotient bits each and a step to register the
// result (results of 0/1, errors and compares skip gcd and division).
// The gcd loop and the shared one-bit-per-cycle divider set the rate; a new item is
// taken once the previous result is in the output register.
module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input logic    clock,
   input logic    reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);
   import rau_pkg::*;

   cmd_type    cmd;
   status_type status;

   rau_controller #(.WORD_BITS(WORD_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_ch.payload),
      .rsp_data  (rsp_ch.payload),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready)
   );

endmodule

>>> sv/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
module rau_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rau_pkg::rsp_type rsp_payload
);
   import rau_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.res_den != 31'd0)
      else $error("zero denominator in result");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error != ERR_NONE |->
         rsp_payload.res_num == 32'sd0 && rsp_payload.res_den == 31'd1
         && rsp_payload.order == ORD_LESS)
      else $error("error result carries data");

endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
